// ===== sv/isd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU stationary detector package
// Shared widths, payload and control types, and register indexes.
// ----------------------------------------------------------------------------
package isd_pkg;

  localparam int GYRO_W   = 16;  // gyro axis sample, two's complement
  localparam int ACCEL_W  = 15;  // accel axis sample, two's complement
  localparam int GMAG_W   = 16;  // gyro magnitude and gyro threshold
  localparam int AMAG_W   = 15;  // accel magnitude, change and threshold
  localparam int RUN_W    = 4;   // run counters and hold count
  localparam int AXES     = 3;

  // Both sums of squares fit 32 bits; the root unit retires one bit a step.
  localparam int SUM_W    = 32;
  localparam int GPROD_W  = 2 * GYRO_W;
  localparam int APROD_W  = 2 * ACCEL_W;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int REM_W    = ROOT_W + 2;
  localparam int CNT_W    = $clog2(ROOT_W);

  localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(AXES);
  localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_W - 1);
  localparam logic [RUN_W-1:0] RUN_MAX   = '1;

  // Configuration port
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int REG_IDX_W = ADDR_W - 2;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_GYRO_THR  = reg_idx_t'(0);
  localparam reg_idx_t REG_ACCEL_THR = reg_idx_t'(1);
  localparam reg_idx_t REG_HOLD      = reg_idx_t'(2);

  localparam logic [GMAG_W-1:0] GYRO_THR_RST  = GMAG_W'(123);
  localparam logic [AMAG_W-1:0] ACCEL_THR_RST = AMAG_W'(8);
  localparam logic [RUN_W-1:0]  HOLD_RST      = RUN_W'(5);

  typedef logic signed [GYRO_W-1:0]  gyro_t;
  typedef logic signed [ACCEL_W-1:0] accel_t;

  typedef struct packed {
    gyro_t  gyro_x;
    gyro_t  gyro_y;
    gyro_t  gyro_z;
    accel_t accel_x;
    accel_t accel_y;
    accel_t accel_z;
  } isd_sample_t;

  typedef struct packed {
    logic              is_stationary;
    logic [GMAG_W-1:0] gyro_magnitude;
    logic [AMAG_W-1:0] accel_magnitude;
    logic [AMAG_W-1:0] accel_change;
    logic [RUN_W-1:0]  run_length;
  } isd_result_t;

  typedef struct packed {
    logic [GMAG_W-1:0] gyro_rate_limit;
    logic [AMAG_W-1:0] accel_change_threshold;
    logic [RUN_W-1:0]  hold_count;
  } isd_cfg_t;

  typedef struct packed {
    logic load;       // capture a new sample, clear the sums
    logic mul_step;   // square the next axis pair
    logic acc_step;   // add the registered squares into the sums
    logic root_step;  // one bit of both square roots
    logic update;     // detector state update and result load
  } isd_cmd_t;

  typedef struct packed {
    logic out_free;   // result register empty or being taken
  } isd_status_t;

endpackage

// ===== sv/isd_sample_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU sample channel
// Valid/ready channel carrying one gyro and accel sample per transaction.
// ----------------------------------------------------------------------------
interface isd_sample_if import isd_pkg::*; ();
  logic   valid;
  logic   ready;
  gyro_t  gyro_x;
  gyro_t  gyro_y;
  gyro_t  gyro_z;
  accel_t accel_x;
  accel_t accel_y;
  accel_t accel_z;

  modport source (output valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                  input ready);
  modport sink (input valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                output ready);
endinterface

// ===== sv/isd_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detector result channel
// Valid/ready channel carrying one detector result per transaction.
// ----------------------------------------------------------------------------
interface isd_result_if import isd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              is_stationary;
  logic [GMAG_W-1:0] gyro_magnitude;
  logic [AMAG_W-1:0] accel_magnitude;
  logic [AMAG_W-1:0] accel_change;
  logic [RUN_W-1:0]  run_length;

  modport source (output valid, is_stationary, gyro_magnitude, accel_magnitude,
                  accel_change, run_length, input ready);
  modport sink (input valid, is_stationary, gyro_magnitude, accel_magnitude,
                accel_change, run_length, output ready);
endinterface

// ===== sv/imu_stationary_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU stationary detector
// Gyro and accel magnitudes with a hysteresis-filtered zero-motion flag.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the valid/ready channel "sample" (three gyro axes and
//   three accel axes); one result per sample leaves on "result". Thresholds
//   and the hold count are written over the APB-style port at byte addresses
//   0, 4 and 8; reads return the current values.
//   Each sample passes from its transaction to a valid result through the
//   squaring phase on the two shared squaring multipliers and their accumulators,
//   sixteen iterations of the bit-per-cycle square root units (gyro and accel
//   run side by side) and an update. The controller then returns to idle to take
//   the next sample. One sample is in flight at a time: the next sample is
//   taken only after the previous one has been updated.
//   The result sits in an output register; a new sample is taken while it
//   waits. If the receiver stalls, the next sample halts before its update
//   until the register is free, and no sample is taken meanwhile.
//   Reset (synchronous, active high) restores the default thresholds, sets the
//   flag to stationary and clears the run counters and accel history.
// ----------------------------------------------------------------------------
module imu_stationary_detector import isd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  isd_sample_if.sink        sample,
  isd_result_if.source      result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  isd_cfg_t    cfg;
  isd_cmd_t    cmd;
  isd_status_t status;
  isd_sample_t sample_data;
  isd_result_t result_data;
  logic        out_valid;
  logic        wr_en;
  reg_idx_t    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gyro_rate_limit        <= GYRO_THR_RST;
      cfg.accel_change_threshold <= ACCEL_THR_RST;
      cfg.hold_count             <= HOLD_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GYRO_THR:  cfg.gyro_rate_limit        <= pwdata[GMAG_W-1:0];
        REG_ACCEL_THR: cfg.accel_change_threshold <= pwdata[AMAG_W-1:0];
        REG_HOLD:      cfg.hold_count             <= pwdata[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GYRO_THR:  prdata = DATA_W'(cfg.gyro_rate_limit);
      REG_ACCEL_THR: prdata = DATA_W'(cfg.accel_change_threshold);
      REG_HOLD:      prdata = DATA_W'(cfg.hold_count);
      default:       prdata = '0;
    endcase
  end

  assign sample_data.gyro_x  = sample.gyro_x;
  assign sample_data.gyro_y  = sample.gyro_y;
  assign sample_data.gyro_z  = sample.gyro_z;
  assign sample_data.accel_x = sample.accel_x;
  assign sample_data.accel_y = sample.accel_y;
  assign sample_data.accel_z = sample.accel_z;

  isd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .status       (status),
    .cmd          (cmd)
  );

  isd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg),
    .sample    (sample_data),
    .out_ready (result.ready),
    .out_valid (out_valid),
    .result    (result_data),
    .status    (status)
  );

  assign result.valid           = out_valid;
  assign result.is_stationary   = result_data.is_stationary;
  assign result.gyro_magnitude  = result_data.gyro_magnitude;
  assign result.accel_magnitude = result_data.accel_magnitude;
  assign result.accel_change    = result_data.accel_change;
  assign result.run_length      = result_data.run_length;

endmodule

// ===== sv/isd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detector controller
// Sequences squaring, square root iterations and the state update per sample.
// ----------------------------------------------------------------------------
module isd_ctrl import isd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_ready,
  input  isd_status_t status,
  output isd_cmd_t    cmd
);

  typedef enum logic [1:0] {IDLE, SQUARE, ROOT, UPDATE} state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    cmd          = '0;
    sample_ready = (state == IDLE);
    case (state)
      IDLE: begin
        if (sample_valid) begin
          cmd.load   = 1'b1;
          state_next = SQUARE;
          cnt_next   = '0;
        end
      end
      SQUARE: begin
        // Products are registered, so each add comes in the cycle after its multiply.
        cmd.mul_step = (cnt < SQ_LAST);
        cmd.acc_step = (cnt != '0);
        cnt_next     = cnt + CNT_W'(1);
        if (cnt == SQ_LAST) begin
          state_next = ROOT;
          cnt_next   = '0;
        end
      end
      ROOT: begin
        cmd.root_step = 1'b1;
        cnt_next      = cnt + CNT_W'(1);
        if (cnt == ROOT_LAST) begin
          state_next = UPDATE;
          cnt_next   = '0;
        end
      end
      UPDATE: begin
        if (status.out_free) begin
          cmd.update = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample_ready) |=> !sample_ready)
    else $error("controller accepted a sample while busy");

  a_update_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> status.out_free)
    else $error("result loaded while the output register was occupied");

  a_phases_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mul_step && cmd.root_step) && !(cmd.load && cmd.update))
    else $error("overlapping datapath commands");

endmodule

// ===== sv/isd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detector datapath
// Squares, square roots, accel change, run counters and the result register.
// ----------------------------------------------------------------------------
module isd_datapath import isd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  isd_cmd_t    cmd,
  input  isd_cfg_t    cfg,
  input  isd_sample_t sample,
  input  logic        out_ready,
  output logic        out_valid,
  output isd_result_t result,
  output isd_status_t status
);

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } root_t;

  // One step of the digit-by-digit square root: bring down two radicand bits.
  function automatic root_t root_iter(root_t cur, logic [1:0] pair);
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] sub;
    root_t            nxt;
    trial = {cur.rem, pair};
    sub   = {2'b00, cur.root, 2'b01};
    if (trial >= sub) begin
      nxt.rem  = REM_W'(trial - sub);
      nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
    end else begin
      nxt.rem  = REM_W'(trial);
      nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

  gyro_t               gyro_axis [AXES];
  accel_t              accel_axis [AXES];
  logic [GPROD_W-1:0]  gprod;
  logic [APROD_W-1:0]  aprod;
  logic [SUM_W-1:0]    gsum, asum;
  root_t               groot, aroot;
  logic [GYRO_W-1:0]   gabs;
  logic [ACCEL_W-1:0]  aabs;

  logic                flag, flag_next;
  logic [RUN_W-1:0]    still_run, still_next;
  logic [RUN_W-1:0]    moving_run, moving_next;
  logic [AMAG_W-1:0]   prev_mag;
  logic [AMAG_W-1:0]   held_change, change_next;
  logic [AMAG_W-1:0]   amag;
  logic [GMAG_W-1:0]   gmag;
  logic [RUN_W-1:0]    still_inc, moving_inc;
  logic                still;

  // Magnitude of the head axis; the most negative code maps to its own magnitude.
  assign gabs = gyro_axis[0][GYRO_W-1] ? (~gyro_axis[0] + GYRO_W'(1)) : gyro_axis[0];
  assign aabs = accel_axis[0][ACCEL_W-1] ? (~accel_axis[0] + ACCEL_W'(1))
                                         : accel_axis[0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gyro_axis  <= '{sample.gyro_x, sample.gyro_y, sample.gyro_z};
      accel_axis <= '{sample.accel_x, sample.accel_y, sample.accel_z};
      gsum       <= '0;
      asum       <= '0;
      groot      <= '0;
      aroot      <= '0;
    end else begin
      if (cmd.mul_step) begin
        gprod <= gabs * gabs;
        aprod <= aabs * aabs;
        for (int i = 0; i < AXES - 1; i++) begin
          gyro_axis[i]  <= gyro_axis[i+1];
          accel_axis[i] <= accel_axis[i+1];
        end
      end
      if (cmd.acc_step) begin
        gsum <= gsum + SUM_W'(gprod);
        asum <= asum + SUM_W'(aprod);
      end
      if (cmd.root_step) begin
        groot <= root_iter(groot, gsum[SUM_W-1 -: 2]);
        aroot <= root_iter(aroot, asum[SUM_W-1 -: 2]);
        gsum  <= {gsum[SUM_W-3:0], 2'b00};
        asum  <= {asum[SUM_W-3:0], 2'b00};
      end
    end
  end

  // The accel sum stays below 2^30, so its root fits the 15-bit field.
  assign gmag = groot.root;
  assign amag = aroot.root[AMAG_W-1:0];

  always_comb begin
    change_next = held_change;
    if (prev_mag != '0) begin
      change_next = (amag >= prev_mag) ? (amag - prev_mag) : (prev_mag - amag);
    end
    still = (gmag < cfg.gyro_rate_limit) && (change_next < cfg.accel_change_threshold);

    still_inc  = (still_run < RUN_MAX) ? still_run + RUN_W'(1) : still_run;
    moving_inc = (moving_run < RUN_MAX) ? moving_run + RUN_W'(1) : moving_run;
    flag_next   = flag;
    still_next  = still_run;
    moving_next = moving_run;
    if (still) begin
      moving_next = '0;
      still_next  = still_inc;
      if (still_inc >= cfg.hold_count) begin
        flag_next  = 1'b1;
        still_next = cfg.hold_count;
      end
    end else begin
      still_next  = '0;
      moving_next = moving_inc;
      if (moving_inc >= cfg.hold_count) begin
        flag_next   = 1'b0;
        moving_next = cfg.hold_count;
      end
    end
  end

  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag        <= 1'b1;
      still_run   <= '0;
      moving_run  <= '0;
      prev_mag    <= '0;
      held_change <= '0;
      out_valid   <= 1'b0;
    end else if (cmd.update) begin
      flag        <= flag_next;
      still_run   <= still_next;
      moving_run  <= moving_next;
      prev_mag    <= amag;
      held_change <= change_next;
      out_valid   <= 1'b1;
    end else if (out_ready) begin
      out_valid   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      result.is_stationary   <= flag_next;
      result.gyro_magnitude  <= gmag;
      result.accel_magnitude <= amag;
      result.accel_change    <= change_next;
      result.run_length      <= flag_next ? still_next : moving_next;
    end
  end

  a_update_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> out_valid && (result.is_stationary == flag))
    else $error("result register does not follow the state update");

  a_run_matches: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> result.run_length == (flag ? still_run : moving_run))
    else $error("run length does not match the active run counter");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !cmd.update |=> $stable(held_change) && $stable(prev_mag) && $stable(flag))
    else $error("detector state changed outside an update");

  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (gsum == '0) && (asum == '0) && (groot == '0))
    else $error("sums not cleared at sample capture");

endmodule
